### hw/rtl/salru_pkg.sv
// salru_pkg: shared constants and types for the set-associative LRU cache lookup.
// Used by salru_ways_ram, salru_lru_update and set_assoc_lru_cache_lookup.
// No dependencies.
package salru_pkg;

	localparam int NUM_SETS    = 256;
	localparam int NUM_WAYS    = 4;
	localparam int BLOCK_BYTES = 64;
	localparam int ADDR_BITS   = 40;

	localparam int ADDR_W   = 40;
	localparam int OFFSET_W = $clog2(BLOCK_BYTES);
	localparam int INDEX_W  = $clog2(NUM_SETS);
	localparam int TAG_W    = ADDR_BITS - OFFSET_W - INDEX_W;
	localparam int WAY_W    = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
	localparam int AGE_W    = WAY_W;
	localparam int CNT_W    = 32;
	localparam int WAY_OUT_W = 2;

	typedef logic [INDEX_W-1:0] index_t;
	typedef logic [TAG_W-1:0]   tag_t;
	typedef logic [WAY_W-1:0]   way_t;
	typedef logic [AGE_W-1:0]   age_t;

	typedef struct packed {
		logic filled;
		age_t age;
		tag_t tag;
	} way_entry_t;

	typedef way_entry_t [NUM_WAYS-1:0] set_row_t;

	typedef struct packed {
		logic   rd_en;
		index_t rd_idx;
		logic   wr_en;
		index_t wr_idx;
	} ram_req_t;

	typedef struct packed {
		logic hit;
		way_t way;
	} lookup_t;

endpackage

### hw/rtl/salru_ways_ram.sv
// salru_ways_ram: per-set row of way tags and ages, one read and one write per cycle.
// Registered read with write-through bypass; per-set valid flags in flops.
// Depends on salru_pkg.
module salru_ways_ram (
	input  logic                clk,
	input  logic                arst_n,
	input  salru_pkg::ram_req_t req,
	input  salru_pkg::set_row_t wr_row,
	output salru_pkg::set_row_t rd_row
);

	salru_pkg::set_row_t mem_q [salru_pkg::NUM_SETS];
	salru_pkg::set_row_t rd_row_s1;
	logic [salru_pkg::NUM_SETS-1:0] set_valid_q;
	logic rd_vld_s1;
	logic bypass;

	assign bypass = req.wr_en && (req.wr_idx == req.rd_idx);

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem_q[req.wr_idx] <= wr_row;
		end
		if (req.rd_en) begin
			rd_row_s1 <= bypass ? wr_row : mem_q[req.rd_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_valid_q <= '0;
			rd_vld_s1   <= 1'b0;
		end else begin
			if (req.wr_en) begin
				set_valid_q[req.wr_idx] <= 1'b1;
			end
			if (req.rd_en) begin
				rd_vld_s1 <= bypass ? 1'b1 : set_valid_q[req.rd_idx];
			end
		end
	end

	// untouched set reads as all ways empty
	always_comb begin
		rd_row = rd_row_s1;
		for (int i = 0; i < salru_pkg::NUM_WAYS; i++) begin
			rd_row[i].filled = rd_row_s1[i].filled & rd_vld_s1;
		end
	end

endmodule

### hw/rtl/salru_lru_update.sv
// salru_lru_update: parallel tag compare, victim choice and true-LRU age update.
// Purely combinational; one set row in, updated row and lookup result out.
// Depends on salru_pkg.
module salru_lru_update (
	input  salru_pkg::set_row_t row,
	input  salru_pkg::tag_t     tag,
	output salru_pkg::set_row_t new_row,
	output salru_pkg::lookup_t  res
);

	logic               hit_any;
	logic               empty_any;
	salru_pkg::way_t    hit_way;
	salru_pkg::way_t    empty_way;
	salru_pkg::way_t    old_way;
	salru_pkg::way_t    sel_way;
	salru_pkg::age_t    mine;

	always_comb begin
		hit_any   = 1'b0;
		empty_any = 1'b0;
		hit_way   = '0;
		empty_way = '0;
		old_way   = '0;
		for (int i = salru_pkg::NUM_WAYS - 1; i >= 0; i--) begin
			if (row[i].filled && row[i].tag == tag) begin
				hit_any = 1'b1;
				hit_way = salru_pkg::WAY_W'(i);
			end
			if (!row[i].filled) begin
				empty_any = 1'b1;
				empty_way = salru_pkg::WAY_W'(i);
			end
			if (row[i].filled && row[i].age == salru_pkg::AGE_W'(salru_pkg::NUM_WAYS - 1)) begin
				old_way = salru_pkg::WAY_W'(i);
			end
		end
		if (hit_any) begin
			sel_way = hit_way;
		end else if (empty_any) begin
			sel_way = empty_way;
		end else begin
			sel_way = old_way;
		end
		mine = row[sel_way].age;

		new_row = row;
		for (int j = 0; j < salru_pkg::NUM_WAYS; j++) begin
			if (salru_pkg::WAY_W'(j) == sel_way) begin
				new_row[j].filled = 1'b1;
				new_row[j].age    = '0;
				new_row[j].tag    = tag;
			end else if (row[j].filled && (!hit_any || row[j].age < mine)) begin
				new_row[j].age = row[j].age + 1'b1;
			end
		end

		res.hit = hit_any;
		res.way = sel_way;
	end

endmodule

### hw/rtl/set_assoc_lru_cache_lookup.sv
// set_assoc_lru_cache_lookup: set-associative cache lookup with true LRU replacement.
// done strobes after the start edge through the vld_s1 and done_q registers; one transaction per cycle.
// The set row is read from the way RAM at acceptance, updated in stage 1 and written back;
// a back-to-back access to the same set takes the written row through a bypass.
// busy is never asserted. Reset clears the set valid flags and the hit/miss counters;
// no clearing pass is needed, so the block takes a transaction on the first cycle out of reset.
module set_assoc_lru_cache_lookup (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [salru_pkg::ADDR_W-1:0]      address,
	output logic                              done,
	output logic                              hit,
	output logic [salru_pkg::WAY_OUT_W-1:0]   way_used,
	output logic [salru_pkg::CNT_W-1:0]       hit_count,
	output logic [salru_pkg::CNT_W-1:0]       miss_count
);

	logic                     accept;
	logic                     vld_s1;
	salru_pkg::tag_t          tag_s1;
	salru_pkg::index_t        idx_s1;
	salru_pkg::ram_req_t      req;
	salru_pkg::set_row_t      rd_row;
	salru_pkg::set_row_t      new_row;
	salru_pkg::lookup_t       res;
	logic                     done_q;
	logic                     hit_q;
	logic [salru_pkg::WAY_OUT_W-1:0] way_q;
	logic [salru_pkg::CNT_W-1:0]     hits_q;
	logic [salru_pkg::CNT_W-1:0]     misses_q;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	assign req.rd_en  = accept;
	assign req.rd_idx = address[salru_pkg::OFFSET_W +: salru_pkg::INDEX_W];
	assign req.wr_en  = vld_s1;
	assign req.wr_idx = idx_s1;

	salru_ways_ram u_ram (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.wr_row (new_row),
		.rd_row (rd_row)
	);

	salru_lru_update u_lru (
		.row     (rd_row),
		.tag     (tag_s1),
		.new_row (new_row),
		.res     (res)
	);

	always_ff @(posedge clk) begin
		if (accept) begin
			tag_s1 <= address[salru_pkg::OFFSET_W + salru_pkg::INDEX_W +: salru_pkg::TAG_W];
			idx_s1 <= address[salru_pkg::OFFSET_W +: salru_pkg::INDEX_W];
		end
		if (vld_s1) begin
			hit_q <= res.hit;
			way_q <= salru_pkg::WAY_OUT_W'(res.way);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1   <= 1'b0;
			done_q   <= 1'b0;
			hits_q   <= '0;
			misses_q <= '0;
		end else begin
			vld_s1 <= accept;
			done_q <= vld_s1;
			if (vld_s1) begin
				if (res.hit) begin
					if (hits_q != '1) begin
						hits_q <= hits_q + 1'b1;
					end
				end else if (misses_q != '1) begin
					misses_q <= misses_q + 1'b1;
				end
			end
		end
	end

	assign done       = done_q;
	assign hit        = hit_q;
	assign way_used   = way_q;
	assign hit_count  = hits_q;
	assign miss_count = misses_q;

`ifndef SYNTH
	a_done_follows_start: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> ##1 done_q)
		else $error("done did not follow accepted transaction");

	a_hit_counts: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && res.hit |=> (hits_q == $past(hits_q) + 1'b1) || (hits_q == '1))
		else $error("hit counter not advanced on hit");

	a_miss_holds_hits: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && !res.hit |=> $stable(hits_q))
		else $error("hit counter changed on miss");

	a_idle_counts_stable: assert property (@(posedge clk) disable iff (!arst_n)
		!vld_s1 |=> $stable(hits_q) && $stable(misses_q))
		else $error("counters changed without a transaction");
`endif

endmodule
